// File: hdl/prtc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prtc_pkg
// Shared constants and codes for the process region table checker.
// ----------------------------------------------------------------------------
package prtc_pkg;

    // Table geometry
    localparam int NUM_SLOTS       = 14;
    localparam int FIRST_USER_SLOT = 2;
    localparam int SLOT_W          = $clog2(NUM_SLOTS);

    // Address arithmetic width, fixed by the 32-bit address fields
    localparam int ADDR_W     = 32;
    localparam int BLOCK_BITS = 9;

    // Channel and field widths
    localparam int STATUS_W   = 3;
    localparam int SLOT_OUT_W = 4;
    localparam int OP_W       = 2;
    localparam int S_DATA_W   = 104;
    localparam int M_DATA_W   = 72;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_CHECK = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_NOSLOT   = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FAULT    = 3'd3,
        ST_NOMEM    = 3'd4
    } status_t;

endpackage

// File: hdl/process_region_table_checker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// process_region_table_checker_unit
// Region table of one process with load, allocate, free and access check.
// ----------------------------------------------------------------------------
// Usage:
//   One request transfer on the s_ channel (operation in s_tuser, the other
//   fields in s_tdata) gives exactly one result transfer on the m_ channel.
//   The single configuration bit split_code_mode is written through
//   cfg_wr_en / cfg_wr_data while no request is in flight.
// Operation:
//   A request first passes a setup step, where the saturating end address is
//   formed by the one shared adder, then walks the slot table one entry per
//   cycle through a single read port. A load skips the walk, and a check that
//   finds its region passes a clip step. The table walk sets the rate.
// Reset:
//   aresetn (synchronous, active low) empties every slot through per-slot
//   valid bits, clears split_code_mode and drops any pending result.
// Stall:
//   The result sits in an output register; s_tready returns as soon as it is
//   loaded there. A finished request waits in its last step while an earlier
//   result is still not taken.
// ----------------------------------------------------------------------------
module process_region_table_checker_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // split_code_mode
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [0] image_slot, [32:1] address, [64:33] length, [96:65] grant_address,
    // [97] write_access, [103:98] zero
    input  logic [prtc_pkg::S_DATA_W-1:0] s_tdata,
    // [1:0] operation
    input  logic [prtc_pkg::OP_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] status, [6:3] slot_index, [38:7] allowed_length,
    // [70:39] region_start_out, [71] zero
    output logic [prtc_pkg::M_DATA_W-1:0] m_tdata
);
    import prtc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_SCAN,
        S_CLIP,
        S_DONE
    } state_t;

    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [SLOT_W-1:0] FIRST_USER = SLOT_W'(FIRST_USER_SLOT);

    // Control and status
    state_t            state_reg;
    logic              split_reg;
    logic              m_tvalid_reg;
    logic [NUM_SLOTS-1:0] valid_reg;
    logic [SLOT_W-1:0] idx_reg;

    // Captured request
    op_t               op_reg;
    logic              img_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] len_reg;
    logic [ADDR_W-1:0] grant_reg;
    logic              wr_reg;

    // Working result
    logic [ADDR_W-1:0] sum_reg;
    logic [ADDR_W-1:0] hit_end_reg;
    status_t           status_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [ADDR_W-1:0] allowed_reg;
    logic [ADDR_W-1:0] rstart_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    // Slot table storage
    logic [ADDR_W-1:0] start_mem [NUM_SLOTS];
    logic [ADDR_W-1:0] end_mem   [NUM_SLOTS];

    // Shared adder and table read
    logic [ADDR_W-1:0]     add_a;
    logic [ADDR_W:0]       add_b;
    logic [ADDR_W-BLOCK_BITS:0] blocks;
    logic [ADDR_W+1:0]     add_sum;
    logic [ADDR_W-1:0]     sat_sum;
    logic [ADDR_W-1:0]     rd_start;
    logic [ADDR_W-1:0]     rd_end;
    logic                  rd_empty;
    logic                  hit;
    logic                  scan_last;
    logic [ADDR_W-1:0]     clip_end;
    logic                  mem_we;
    logic [SLOT_W-1:0]     mem_waddr;
    logic [ADDR_W-1:0]     mem_wstart;
    logic [ADDR_W-1:0]     mem_wend;
    logic                  out_free;

    // For an allocation, round the size up to whole blocks; then add with saturation
    always_comb begin
        blocks  = {1'b0, len_reg[ADDR_W-1:BLOCK_BITS]}
                  + (ADDR_W-BLOCK_BITS+1)'(|len_reg[BLOCK_BITS-1:0]);
        add_a   = (op_reg == OP_ALLOC) ? grant_reg : addr_reg;
        add_b   = (op_reg == OP_ALLOC) ? {blocks, {BLOCK_BITS{1'b0}}}
                                       : {1'b0, len_reg};
        add_sum = {2'b00, add_a} + {1'b0, add_b};
        sat_sum = (add_sum[ADDR_W+1:ADDR_W] != 2'b00) ? {ADDR_W{1'b1}}
                                                       : add_sum[ADDR_W-1:0];
    end

    // Read the slot under the walk; an unwritten slot reads as empty
    always_comb begin
        rd_start  = valid_reg[idx_reg] ? start_mem[idx_reg] : '0;
        rd_end    = valid_reg[idx_reg] ? end_mem[idx_reg]   : '0;
        rd_empty  = (rd_start == '0);
        hit       = !rd_empty && (addr_reg >= rd_start) && (addr_reg < rd_end);
        scan_last = (idx_reg == LAST_SLOT);
        clip_end  = (sum_reg >= hit_end_reg) ? hit_end_reg : sum_reg;
        out_free  = !m_tvalid_reg || m_tready;
    end

    // Table write port
    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = idx_reg;
        mem_wstart = grant_reg;
        mem_wend   = sum_reg;
        if (state_reg == S_PREP && op_reg == OP_LOAD) begin
            mem_we     = 1'b1;
            mem_waddr  = SLOT_W'(img_reg);
            mem_wstart = addr_reg;
            mem_wend   = sat_sum;
        end else if (state_reg == S_SCAN && op_reg == OP_ALLOC && rd_empty
                     && grant_reg != '0) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            start_mem[mem_waddr] <= mem_wstart;
            end_mem[mem_waddr]   <= mem_wend;
        end
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            split_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
            valid_reg    <= '0;
            idx_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                split_reg <= cfg_wr_data;
            end
            // Raise the result when it is loaded, drop it once taken
            if (state_reg == S_DONE && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (mem_we) begin
                valid_reg[mem_waddr] <= 1'b1;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg    <= op_t'(s_tuser);
                        img_reg   <= s_tdata[0];
                        addr_reg  <= s_tdata[32:1];
                        len_reg   <= s_tdata[64:33];
                        grant_reg <= s_tdata[96:65];
                        wr_reg    <= s_tdata[97];
                        state_reg <= S_PREP;
                    end
                end
                S_PREP: begin
                    sum_reg     <= sat_sum;
                    allowed_reg <= '0;
                    rstart_reg  <= '0;
                    unique case (op_reg)
                        OP_LOAD: begin
                            status_reg <= ST_OK;
                            slot_reg   <= SLOT_W'(img_reg);
                            state_reg  <= S_DONE;
                        end
                        OP_ALLOC: begin
                            status_reg <= ST_NOSLOT;
                            slot_reg   <= '0;
                            idx_reg    <= FIRST_USER;
                            state_reg  <= S_SCAN;
                        end
                        OP_FREE: begin
                            status_reg <= ST_NOTFOUND;
                            slot_reg   <= '0;
                            idx_reg    <= FIRST_USER;
                            // A zero address never matches
                            state_reg  <= (addr_reg == '0) ? S_DONE : S_SCAN;
                        end
                        OP_CHECK: begin
                            status_reg <= ST_FAULT;
                            slot_reg   <= '0;
                            // Write checks skip the code slot in split mode
                            idx_reg    <= (split_reg && wr_reg) ? SLOT_W'(1) : '0;
                            state_reg  <= S_SCAN;
                        end
                        default: begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_SCAN: begin
                    // Advance one slot per cycle until a match or the end
                    idx_reg <= idx_reg + SLOT_W'(1);
                    unique case (op_reg)
                        OP_ALLOC: begin
                            if (rd_empty) begin
                                state_reg <= S_DONE;
                                if (grant_reg == '0) begin
                                    status_reg <= ST_NOMEM;
                                end else begin
                                    status_reg <= ST_OK;
                                    slot_reg   <= idx_reg;
                                    rstart_reg <= grant_reg;
                                end
                            end else if (scan_last) begin
                                state_reg <= S_DONE;
                            end
                        end
                        OP_FREE: begin
                            if (rd_start == addr_reg) begin
                                valid_reg[idx_reg] <= 1'b0;
                                status_reg         <= ST_OK;
                                slot_reg           <= idx_reg;
                                state_reg          <= S_DONE;
                            end else if (scan_last) begin
                                state_reg <= S_DONE;
                            end
                        end
                        OP_CHECK: begin
                            if (hit) begin
                                hit_end_reg <= rd_end;
                                slot_reg    <= idx_reg;
                                state_reg   <= S_CLIP;
                            end else if (scan_last) begin
                                state_reg <= S_DONE;
                            end
                        end
                        default: begin
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_CLIP: begin
                    // Clip the access to the region end; empty access faults
                    if (clip_end != addr_reg) begin
                        status_reg  <= ST_OK;
                        allowed_reg <= clip_end - addr_reg;
                    end else begin
                        slot_reg <= '0;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE: begin
                    // Hold until the output register is free
                    if (out_free) begin
                        m_tdata_reg  <= {1'b0, rstart_reg, allowed_reg,
                                         SLOT_OUT_W'(slot_reg), status_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A request is never taken while one is in flight
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // A failed result carries no slot, length or start
    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] != ST_OK) |->
            (m_tdata[6:3] == '0) && (m_tdata[38:7] == '0) && (m_tdata[70:39] == '0))
        else $error("failed result carries payload");

    // The walk never leaves the table
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (idx_reg <= LAST_SLOT))
        else $error("slot walk out of range");

    // A granted region always reports its start and a user slot
    a_alloc_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[70:39] != '0) |->
            (m_tdata[2:0] == ST_OK) && (m_tdata[6:3] >= SLOT_OUT_W'(FIRST_USER_SLOT)))
        else $error("allocation result inconsistent");

    // A result is loaded only when the previous one has gone
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) && m_tvalid_reg && !m_tready |=> (state_reg == S_DONE))
        else $error("result overwritten while stalled");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the process region table checker unit.
// ----------------------------------------------------------------------------
// Requests go in on the s_ stream and each one gives a single result on the
// m_ stream. A scoreboard keeps its own copy of the region table and the
// split code mode bit. It works out the result of every accepted request and
// compares each returned result with the oldest outstanding one, field by
// field. A short directed sequence covers the corner cases. It is followed by
// constrained-random traffic, mostly aimed at regions that are really in the
// table. Both sides idle at random in two of the three phases; the split mode
// bit is rewritten at the start and middle of each, once the unit has drained.
// ----------------------------------------------------------------------------
module tb_top;
    import prtc_pkg::*;

    typedef struct packed {
        op_t               op;
        logic              image_slot;
        logic [ADDR_W-1:0] address;
        logic [31:0]       length;
        logic [ADDR_W-1:0] grant;
        logic              write_access;
    } table_request_t;

    typedef struct packed {
        status_t               status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [31:0]           allowed_length;
        logic [ADDR_W-1:0]     region_start;
    } table_result_t;

    // Region table mirror and queue of results still owed by the unit
    class region_table_scoreboard;
        logic [ADDR_W-1:0] slot_start [NUM_SLOTS];
        logic [ADDR_W-1:0] slot_end   [NUM_SLOTS];
        bit                split_mode;
        table_result_t     owed[$];
        int                errors;

        function new();
            int i;
            for (i = 0; i < NUM_SLOTS; i++) begin
                slot_start[i] = '0;
                slot_end[i]   = '0;
            end
            split_mode = 1'b0;
            errors     = 0;
        endfunction

        function void set_split_mode(bit mode);
            split_mode = mode;
        endfunction

        // a + b, clamped to the top of the address space
        function logic [ADDR_W-1:0] sat_sum(input logic [ADDR_W-1:0] a,
                                            input logic [ADDR_W:0] b);
            logic [ADDR_W+1:0] s;
            s = {2'b00, a} + {1'b0, b};
            if (s > {2'b00, {ADDR_W{1'b1}}})
                return {ADDR_W{1'b1}};
            return s[ADDR_W-1:0];
        endfunction

        // Apply one accepted request to the table and queue its result
        function void note_request(input table_request_t rq);
            table_result_t     r;
            int                i;
            int                first;
            bit                done;
            logic [ADDR_W:0]   size;
            logic [ADDR_W-1:0] e;
            r.status         = ST_OK;
            r.slot           = '0;
            r.allowed_length = '0;
            r.region_start   = '0;
            done             = 1'b0;
            case (rq.op)
                OP_LOAD: begin
                    slot_start[rq.image_slot] = rq.address;
                    slot_end[rq.image_slot]   = sat_sum(rq.address, {1'b0, rq.length});
                    r.slot = {3'b000, rq.image_slot};
                end
                OP_ALLOC: begin
                    // round up to whole 512-byte blocks, no wrap
                    size = ({1'b0, rq.length} + 33'd511) & ~33'd511;
                    r.status = ST_NOSLOT;
                    for (i = FIRST_USER_SLOT; i < NUM_SLOTS; i++) begin
                        if (!done && slot_start[i] == '0) begin
                            done = 1'b1;
                            if (rq.grant == '0) begin
                                r.status = ST_NOMEM;
                            end else begin
                                slot_start[i]  = rq.grant;
                                slot_end[i]    = sat_sum(rq.grant, size);
                                r.status       = ST_OK;
                                r.slot         = 4'(i);
                                r.region_start = rq.grant;
                            end
                        end
                    end
                end
                OP_FREE: begin
                    r.status = ST_NOTFOUND;
                    if (rq.address != '0) begin
                        for (i = FIRST_USER_SLOT; i < NUM_SLOTS; i++) begin
                            if (!done && slot_start[i] == rq.address) begin
                                done          = 1'b1;
                                slot_start[i] = '0;
                                slot_end[i]   = '0;
                                r.status      = ST_OK;
                                r.slot        = 4'(i);
                            end
                        end
                    end
                end
                default: begin
                    // code slot is invisible to writes in split mode
                    first    = (split_mode && rq.write_access) ? 1 : 0;
                    r.status = ST_FAULT;
                    for (i = first; i < NUM_SLOTS; i++) begin
                        if (!done && slot_start[i] != '0 && rq.address >= slot_start[i] &&
                                rq.address < slot_end[i]) begin
                            done = 1'b1;
                            e = sat_sum(rq.address, {1'b0, rq.length});
                            if (e >= slot_end[i])
                                e = slot_end[i];
                            if (e != rq.address) begin
                                r.status         = ST_OK;
                                r.slot           = 4'(i);
                                r.allowed_length = e - rq.address;
                            end
                        end
                    end
                end
            endcase
            owed.push_back(r);
        endfunction

        // Compare a returned result with the oldest one owed
        function void check_result(input table_result_t got);
            table_result_t exp;
            if (owed.size() == 0) begin
                $display("%0t: result with none outstanding, got status %0d slot %0d",
                         $time, got.status, got.slot);
                errors++;
                return;
            end
            exp = owed.pop_front();
            if (got.status != exp.status) begin
                $display("%0t: status mismatch, expected %0d, got %0d",
                         $time, exp.status, got.status);
                errors++;
            end
            if (got.slot != exp.slot) begin
                $display("%0t: slot_index mismatch, expected %0d, got %0d",
                         $time, exp.slot, got.slot);
                errors++;
            end
            if (got.allowed_length != exp.allowed_length) begin
                $display("%0t: allowed_length mismatch, expected %h, got %h",
                         $time, exp.allowed_length, got.allowed_length);
                errors++;
            end
            if (got.region_start != exp.region_start) begin
                $display("%0t: region_start_out mismatch, expected %h, got %h",
                         $time, exp.region_start, got.region_start);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic                  cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [OP_W-1:0]       s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;

    region_table_scoreboard sb;
    int                     send_idle_pct;
    int                     recv_idle_pct;
    table_result_t          seen;

    process_region_table_checker_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the unit hangs
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Receiver back-pressure, changed on the falling edge
    initial m_tready = 1'b0;
    always @(negedge aclk)
        m_tready = ($urandom_range(0, 99) >= recv_idle_pct);

    // Check every result transfer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen.status         = status_t'(m_tdata[2:0]);
            seen.slot           = m_tdata[6:3];
            seen.allowed_length = m_tdata[38:7];
            seen.region_start   = m_tdata[70:39];
            sb.check_result(seen);
        end
    end

    function automatic table_request_t make_request(input op_t op, input logic img,
                                                    input logic [31:0] addr,
                                                    input logic [31:0] len,
                                                    input logic [31:0] grant,
                                                    input logic wr);
        table_request_t rq;
        rq.op           = op;
        rq.image_slot   = img;
        rq.address      = addr;
        rq.length       = len;
        rq.grant        = grant;
        rq.write_access = wr;
        return rq;
    endfunction

    function automatic logic [31:0] random_length();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            3:       return $urandom_range(1, 15);
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    function automatic logic [31:0] random_address();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return 32'hFFFF_F000 | $urandom_range(0, 4095);
            default: return 32'h0010_0000 + $urandom_range(0, 32'h3_FFFF);
        endcase
    endfunction

    function automatic logic [31:0] random_grant();
        case ($urandom_range(0, 19))
            0:       return 32'd0;
            1:       return $urandom;
            2:       return 32'hFFFF_FE00;
            default: return 32'h0010_0000 + ($urandom_range(0, 511) << 9);
        endcase
    endfunction

    // Mostly well-formed traffic aimed at live regions, the rest noise
    function automatic table_request_t random_request();
        table_request_t rq;
        int             live[$];
        int             i;
        int             pick;
        int             r;
        logic [31:0]    span;
        rq.image_slot   = 1'($urandom_range(0, 1));
        rq.address      = $urandom;
        rq.length       = $urandom;
        rq.grant        = $urandom;
        rq.write_access = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 99);
        if (r < 8) begin
            rq.op      = OP_LOAD;
            rq.address = ($urandom_range(0, 19) == 0) ? 32'd0 : random_address();
            rq.length  = random_length();
        end else if (r < 33) begin
            rq.op     = OP_ALLOC;
            rq.length = random_length();
            rq.grant  = random_grant();
        end else if (r < 63) begin
            rq.op = OP_FREE;
            for (i = FIRST_USER_SLOT; i < NUM_SLOTS; i++)
                if (sb.slot_start[i] != '0)
                    live.push_back(i);
            pick = $urandom_range(0, 9);
            if (pick < 7 && live.size() > 0)
                rq.address = sb.slot_start[live[$urandom_range(0, live.size() - 1)]];
            else if (pick < 8)
                rq.address = 32'd0;
            else if (pick < 9)
                rq.address = sb.slot_start[$urandom_range(0, 1)];
            else
                rq.address = random_address();
        end else begin
            rq.op     = OP_CHECK;
            rq.length = random_length();
            for (i = 0; i < NUM_SLOTS; i++)
                if (sb.slot_start[i] != '0)
                    live.push_back(i);
            if (live.size() > 0 && $urandom_range(0, 3) != 0) begin
                pick = live[$urandom_range(0, live.size() - 1)];
                span = sb.slot_end[pick] - sb.slot_start[pick];
                case ($urandom_range(0, 5))
                    0:       rq.address = sb.slot_end[pick];
                    1:       rq.address = sb.slot_start[pick] - 32'd1;
                    2:       rq.address = sb.slot_end[pick] - 32'd1;
                    default: rq.address = sb.slot_start[pick] +
                                          ((span == '0) ? 32'd0 : ($urandom % span));
                endcase
            end else begin
                rq.address = random_address();
            end
        end
        return rq;
    endfunction

    // Drive one request; entered and left on a falling edge
    task automatic send_request(input table_request_t rq);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {6'b0, rq.write_access, rq.grant, rq.length, rq.address, rq.image_slot};
        s_tuser  = rq.op;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(rq);
        @(negedge aclk);
    endtask

    // Hold off until every owed result is back and the unit has settled
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (sb.owed.size() != 0)
            @(negedge aclk);
        repeat (24) @(negedge aclk);
    endtask

    task automatic write_split_mode(input bit mode);
        wait_drained();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = mode;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        sb.set_split_mode(mode);
    endtask

    initial begin
        int k;
        int ph;
        int m;
        sb            = new();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = OP_LOAD;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed corner cases, split mode off
        write_split_mode(1'b0);
        send_request(make_request(OP_CHECK, 1'b0, 32'h1000, 32'd4, 32'd0, 1'b0));
        send_request(make_request(OP_LOAD, 1'b0, 32'h1000, 32'h800, 32'd0, 1'b0));
        send_request(make_request(OP_LOAD, 1'b1, 32'h4000, 32'h400, 32'd0, 1'b0));
        send_request(make_request(OP_CHECK, 1'b0, 32'h1000, 32'h10, 32'd0, 1'b1));
        send_request(make_request(OP_CHECK, 1'b0, 32'h17F0, 32'h100, 32'd0, 1'b0));
        send_request(make_request(OP_CHECK, 1'b0, 32'h1000, 32'd0, 32'd0, 1'b0));
        send_request(make_request(OP_ALLOC, 1'b0, 32'd0, 32'd0, 32'h1_0000, 1'b0));
        send_request(make_request(OP_CHECK, 1'b0, 32'h1_0000, 32'd4, 32'd0, 1'b0));
        send_request(make_request(OP_ALLOC, 1'b0, 32'd0, 32'd1, 32'h2_0000, 1'b0));
        send_request(make_request(OP_ALLOC, 1'b0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_F000,
                                  1'b0));
        send_request(make_request(OP_ALLOC, 1'b0, 32'd0, 32'h200, 32'd0, 1'b0));
        send_request(make_request(OP_CHECK, 1'b0, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'd0,
                                  1'b1));
        send_request(make_request(OP_FREE, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0));
        send_request(make_request(OP_FREE, 1'b0, 32'h1000, 32'd0, 32'd0, 1'b0));
        send_request(make_request(OP_FREE, 1'b0, 32'h2_0000, 32'd0, 32'd0, 1'b0));
        send_request(make_request(OP_LOAD, 1'b1, 32'd0, 32'd5, 32'd0, 1'b0));
        send_request(make_request(OP_LOAD, 1'b1, 32'hFFFF_FF00, 32'h1000, 32'd0, 1'b0));
        // fill every user slot, then ask once more with a failed grant
        for (k = 0; k < 10; k++)
            send_request(make_request(OP_ALLOC, 1'b0, 32'd0, 32'(k * 100),
                                      32'(32'h3_0000 + k * 32'h1000), 1'b0));
        send_request(make_request(OP_ALLOC, 1'b0, 32'd0, 32'h40, 32'd0, 1'b0));

        // Code slot hidden from writes only
        write_split_mode(1'b1);
        send_request(make_request(OP_CHECK, 1'b0, 32'h1000, 32'h20, 32'd0, 1'b1));
        send_request(make_request(OP_CHECK, 1'b0, 32'h1000, 32'h20, 32'd0, 1'b0));

        // Random traffic across three phases, two with idling, both modes in each
        for (ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 29 : (ph == 1) ? 74 : 0;
            recv_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 29 : 0;
            for (m = 0; m < 2; m++) begin
                write_split_mode(1'((ph + m) % 2));
                repeat (280) send_request(random_request());
            end
        end

        wait_drained();
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
